// ===== src/tunnel_effect_pixel_shader_top_defines.svh =====
// assertion macros for the tunnel shader
`ifndef TUNNEL_EFFECT_PIXEL_SHADER_TOP_DEFINES_SVH
`define TUNNEL_EFFECT_PIXEL_SHADER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TEPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define TEPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/teps_pkg.sv =====
package teps_pkg;

    localparam int MaxDimDefault = 1024;
    localparam int DimW   = 11;
    localparam int PixW   = 10;
    localparam int TimeW  = 9;
    localparam int SqW    = 24;
    localparam int RootW  = SqW / 2;
    localparam int DepthNum = 3000;
    localparam int DivSteps = 12;
    localparam int AngW   = 6;

    localparam logic [0:0] RegWidth  = 1'b0;
    localparam logic [0:0] RegHeight = 1'b1;

    typedef struct packed {
        logic [PixW-1:0]  pix_x;
        logic [PixW-1:0]  pix_y;
        logic [TimeW-1:0] frame_time;
    } teps_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } teps_out_t;

    // working set carried from cell to cell
    typedef struct packed {
        logic [SqW-1:0]   rem;
        logic [RootW-1:0] root;
        logic [12:0]      aden;
        logic [16:0]      arem;
        logic [AngW-1:0]  aq;
        logic             sx;
        logic             sy;
        logic [TimeW-1:0] t;
    } teps_work_t;

    // floor(v/255) for v <= 255*240
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [24:0] p;
        logic [8:0]  q;
        logic [15:0] r;
        begin
            p = 25'(v) * 25'd257;
            q = 9'(p >> 16);
            r = v - 16'(q) * 16'd255;
            if (r >= 16'd255)
                q = q + 9'd1;
            div255 = q[7:0];
        end
    endfunction

endpackage

// ===== src/teps_cell.sv =====
// a square root step per cell; an angle division step if Stage < AngW
module teps_cell
    import teps_pkg::*;
#(
    parameter int Stage = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       vin,
    input  teps_work_t win,
    output logic       vout,
    output teps_work_t wout
);
    localparam int Shift = 2 * (RootW - 1 - Stage);
    localparam logic [SqW-1:0] Bit = SqW'(1) << Shift;

    logic       v_reg;
    teps_work_t w_reg;
    teps_work_t w_next;
    logic [SqW-1:0] trial;
    logic [16:0]    arem2;

    always_comb
    begin
        w_next = win;
        trial  = (SqW'(win.root) << (RootW - Stage)) + Bit;
        if (win.rem >= trial)
        begin
            w_next.rem  = win.rem - trial;
            w_next.root = win.root | RootW'(RootW'(1) << (RootW - 1 - Stage));
        end
        // first step gives the integer bit, the rest the fraction bits
        arem2 = (Stage == 0) ? win.arem : {win.arem[15:0], 1'b0};
        if (Stage < AngW)
        begin
            if (arem2 >= 17'(win.aden))
            begin
                w_next.arem = arem2 - 17'(win.aden);
                w_next.aq   = {win.aq[AngW-2:0], 1'b1};
            end
            else
            begin
                w_next.arem = arem2;
                w_next.aq   = {win.aq[AngW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            w_reg <= w_next;
    end

    assign vout = v_reg;
    assign wout = w_reg;
endmodule

// ===== src/teps_shade.sv =====
// depth divider cells then colour lookup
module teps_shade
    import teps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vin,
    input  logic [RootW-1:0] root,
    input  logic [AngW-1:0]  aq,
    input  logic             sx,
    input  logic             sy,
    input  logic [TimeW-1:0] t,
    output logic             vout,
    output teps_out_t        pix
);
    // restoring division chain for 3000 / d, one quotient bit per stage
    logic [DivSteps:0]            v_reg;
    logic [DivSteps:0][12:0]      rem_reg;
    logic [DivSteps:0][11:0]      q_reg;
    logic [DivSteps:0][RootW-1:0] d_reg;
    logic [DivSteps:0][7:0]       ang_reg;
    logic [DivSteps:0][TimeW-1:0] t_reg;
    logic [7:0] ang;
    logic [AngW-1:0] a;
    logic [RootW-1:0] dcl;

    always_comb
    begin
        a = aq;
        dcl = (root == '0) ? RootW'(1) : root;
        if (!sx && !sy)      ang = 8'(a);
        else if (sx && !sy)  ang = 8'd64 - 8'(a);
        else if (sx)         ang = 8'd128 + 8'(a);
        else                 ang = 8'd192 - 8'(a);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DivSteps-1:0], vin};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            d_reg[0]   <= dcl;
            ang_reg[0] <= ang;
            t_reg[0]   <= t;
            for (int i = 0; i < DivSteps; i++)
            begin
                logic [12:0] r2;
                r2 = {rem_reg[i][11:0], 1'(DepthNum >> (DivSteps - 1 - i))};
                if (r2 >= 13'(d_reg[i]))
                begin
                    rem_reg[i+1] <= r2 - 13'(d_reg[i]);
                    q_reg[i+1]   <= {q_reg[i][10:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= r2;
                    q_reg[i+1]   <= {q_reg[i][10:0], 1'b0};
                end
                d_reg[i+1]   <= d_reg[i];
                ang_reg[i+1] <= ang_reg[i];
                t_reg[i+1]   <= t_reg[i];
            end
        end
    end

    logic [7:0] depth, u, v, shade;
    logic       chk;
    logic [7:0] kr, kg, kb;

    always_comb
    begin
        depth = q_reg[DivSteps][7:0];
        u     = depth + t_reg[DivSteps][7:0];
        v     = ang_reg[DivSteps] + t_reg[DivSteps][8:1];
        chk   = u[4] ^ v[4];
        shade = 8'd255 - depth;
        kr = chk ? 8'd240 : 8'd60;
        kg = chk ? 8'd120 : 8'd70;
        kb = chk ? 8'd60  : 8'd200;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout <= 1'b0;
        else if (en)
            vout <= v_reg[DivSteps];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix.red   <= div255(16'(shade) * 16'(kr));
            pix.green <= div255(16'(shade) * 16'(kg));
            pix.blue  <= div255(16'(shade) * 16'(kb));
        end
    end
endmodule

// ===== src/tunnel_effect_pixel_shader_top.sv =====
// tunnel effect pixel shader
// input channel: in_valid / in_stall with a packed item of pix_x, pix_y,
// frame_time; output channel: out_valid / out_stall with red, green, blue
// an item enters at every clock edge where in_valid is high and in_stall low
// the datapath is a chain of cells: one setup stage forms offsets and squares,
// twelve square root cells (which also carry six angle division steps),
// a divider load stage, twelve depth divider cells and one shading stage
// throughput: one item per cycle while not stalled, set by the cell chain advancing every enabled cycle
// the whole chain freezes while out_valid is high and out_stall is high,
// so a stalled result holds and in_stall follows the output stall
// reset clears all valid bits and loads width 110, height 64
// apb writes land at byte 0 (width) and 4 (height); pready is tied high
module tunnel_effect_pixel_shader_top
    import teps_pkg::*;
#(
    parameter int MAX_DIM = MaxDimDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  teps_in_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output teps_out_t   out_item
);
    logic [DimW-1:0] width_reg, height_reg;
    logic            en;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(height_reg) : 32'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DimW'(110);
            height_reg <= DimW'(64);
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == RegWidth)
                width_reg <= pwdata[DimW-1:0];
            else
                height_reg <= pwdata[DimW-1:0];
        end
    end

    // stall the whole chain only while a result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // setup stage: centre, offsets, squares and angle operands
    logic [DimW-1:0] cw, ch;
    logic signed [DimW:0] dx, dy;
    logic [DimW-1:0] ax, ay;
    logic            v0_reg;
    teps_work_t      w0_reg, w0_next;

    always_comb
    begin
        // a limit beyond the register range never clamps
        cw = (32'(width_reg)  > 32'(MAX_DIM)) ? DimW'(MAX_DIM) : width_reg;
        ch = (32'(height_reg) > 32'(MAX_DIM)) ? DimW'(MAX_DIM) : height_reg;
        dx = $signed({2'b00, in_item.pix_x}) - $signed({2'b00, cw[DimW-1:1]});
        dy = $signed({2'b00, in_item.pix_y}) - $signed({2'b00, ch[DimW-1:1]});
        ax = dx[DimW] ? DimW'(-dx) : dx[DimW-1:0];
        ay = dy[DimW] ? DimW'(-dy) : dy[DimW-1:0];
        w0_next.rem  = SqW'(ax) * SqW'(ax) + SqW'(ay) * SqW'(ay);
        w0_next.root = '0;
        w0_next.aden = 13'(ax) + 13'(ay);
        // 32*ay / (ax+ay): preload ay, six restoring steps give the quotient
        w0_next.arem = 17'(ay);
        w0_next.aq   = '0;
        w0_next.sx   = dx[DimW];
        w0_next.sy   = dy[DimW];
        w0_next.t    = in_item.frame_time;
        if (w0_next.aden == '0)
            w0_next.arem = '0;
        if (w0_next.aden == '0)
            w0_next.aden = 13'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            w0_reg <= w0_next;
    end

    logic       [RootW:0] vc;
    teps_work_t [RootW:0] wc;
    assign vc[0] = v0_reg;
    assign wc[0] = w0_reg;

    for (genvar g = 0; g < RootW; g++)
    begin : g_cell
        teps_cell #(.Stage(g)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .vin  (vc[g]),
            .win  (wc[g]),
            .vout (vc[g+1]),
            .wout (wc[g+1])
        );
    end

    teps_shade u_shade (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (vc[RootW]),
        .root (wc[RootW].root),
        .aq   (wc[RootW].aq),
        .sx   (wc[RootW].sx),
        .sy   (wc[RootW].sy),
        .t    (wc[RootW].t),
        .vout (out_valid),
        .pix  (out_item)
    );
endmodule

// ===== src/teps_checker.sv =====
`include "tunnel_effect_pixel_shader_top_defines.svh"
// port level checks for the tunnel shader
module teps_checker
    import teps_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input teps_out_t out_item,
    input logic      pready
);
    `TEPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
    `TEPS_ASSERT_IMP(a_in_stall_only_when_held, in_stall, out_valid && out_stall)
    `TEPS_ASSERT_IMP(a_pready_high, 1'b1, pready)
endmodule

bind tunnel_effect_pixel_shader_top teps_checker u_teps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .pready   (pready)
);
